>>> rtl/btmmc_pkg.sv
// Shared types and constants for the box tile map move check block.
// No dependencies.
package btmmc_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MOVE  = 1'b1;

  localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAP_COLUMNS = 2'd2;

  // Coordinate width: 16-bit position plus 10-bit size plus 11-bit move.
  localparam int COORD_W = 18;
  localparam int QUOT_W  = 18;

  // Classified item passed from front to back.
  typedef struct packed {
    logic                      is_move;
    logic [11:0]               tile_index;
    logic                      tile_blocked;
    logic signed [COORD_W-1:0] x0;      // x corner a
    logic signed [COORD_W-1:0] x1;      // x corner b
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] ex;      // leading x for the x check
    logic signed [COORD_W-1:0] ey;      // leading y for the y check
    logic signed [10:0]        move_x;
    logic signed [10:0]        move_y;
  } item_t;

endpackage

>>> rtl/btmmc_front.sv
// Front end: accepts items and computes corner coordinates.
// Depends on btmmc_pkg.
module btmmc_front
  import btmmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  logic               command,
  input  logic [11:0]        tile_index,
  input  logic               tile_blocked,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [9:0]         box_w,
  input  logic [9:0]         box_h,
  input  logic signed [10:0] move_x,
  input  logic signed [10:0] move_y,
  input  logic               busy,
  output logic               q_valid,
  input  logic               q_stall,
  output item_t              q_item
);

  logic signed [COORD_W-1:0] px, py, pxw, pyh, mx, my;
  item_t it;

  always_comb begin
    px  = COORD_W'(pos_x);
    py  = COORD_W'(pos_y);
    pxw = px + COORD_W'($signed({1'b0, box_w}));
    pyh = py + COORD_W'($signed({1'b0, box_h}));
    mx  = COORD_W'(move_x);
    my  = COORD_W'(move_y);
    it.is_move      = (command == CMD_MOVE);
    it.tile_index   = tile_index;
    it.tile_blocked = tile_blocked;
    it.x0 = px;
    it.x1 = pxw;
    it.y0 = py;
    it.y1 = pyh;
    it.ex = (move_x > 0) ? pxw + mx : px + mx;
    it.ey = (move_y > 0) ? pyh + my : py + my;
    it.move_x = move_x;
    it.move_y = move_y;
  end

  // one-entry queue toward the back end
  assign stall = q_valid || busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (valid && !stall) begin
      q_valid <= 1'b1;
      q_item  <= it;
    end else if (q_valid && !q_stall) begin
      q_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/btmmc_divider.sv
// Sequential floor divider: signed dividend by unsigned 9-bit divisor.
// Depends on btmmc_pkg.
module btmmc_divider
  import btmmc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] dividend,
  input  logic [8:0]                divisor,
  output logic                      done,
  output logic signed [QUOT_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic [COORD_W-1:0] mag, quo;
  logic [9:0]         rem;
  logic [8:0]         dv;
  logic               neg, running;
  logic [CNT_W-1:0]   cnt;
  logic [9:0]         trial;

  always_comb begin
    trial = {rem[8:0], mag[COORD_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        neg <= dividend[COORD_W-1];
        // ones' complement folds floor: -a/d floors to ~((a'-1)/d) form
        mag <= dividend[COORD_W-1] ? ~dividend : dividend;
        dv  <= (divisor == 9'd0) ? 9'd1 : divisor;
        rem <= '0;
        quo <= '0;
        cnt <= CNT_W'(COORD_W);
      end else if (running) begin
        mag <= {mag[COORD_W-2:0], 1'b0};
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
          quo <= {quo[COORD_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[COORD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // floor(a/d) for a<0 equals -1 - floor((-a-1)/d) = ~floor(~a/d)
  assign quotient = neg ? ~$signed(quo) : $signed(quo);

endmodule

>>> rtl/btmmc_back.sv
// Back end: tile map memory, clear sweep, and the per-axis check sequencer.
// Depends on btmmc_pkg and btmmc_divider.
module btmmc_back
  import btmmc_pkg::*;
#(
  parameter int MAP_TILES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [8:0]         tile_width,
  input  logic [8:0]         tile_height,
  input  logic [8:0]         map_columns,
  input  logic               q_valid,
  output logic               q_stall,
  input  item_t              q_item,
  output logic               busy,
  output logic               valid,
  input  logic               stall,
  output logic signed [10:0] allowed_x,
  output logic signed [10:0] allowed_y,
  output logic               x_stopped,
  output logic               y_stopped
);

  localparam int AW = $clog2(MAP_TILES);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_WAIT  = 8'b00001000,
    S_ADDR  = 8'b00010000,
    S_READ  = 8'b00100000,
    S_CHECK = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  item_t  cur;
  logic [1:0] corner;   // 0..3: x axis top/bottom, y axis left/right
  logic       half;     // 0 column divide, 1 row divide
  logic signed [QUOT_W-1:0] col, row;
  logic       bad, blk_x, blk_y;
  logic [AW:0] clr;
  logic        mem [MAP_TILES];
  logic        rd;
  logic [AW-1:0] addr;

  // finished result waiting for the output register
  logic signed [10:0] res_x, res_y;
  logic               res_sx, res_sy;
  logic               out_load;

  // divider operand choice
  logic                      d_start, d_done;
  logic signed [COORD_W-1:0] d_a;
  logic [8:0]                d_d;
  logic signed [QUOT_W-1:0]  d_q;
  logic signed [COORD_W-1:0] px, py;

  always_comb begin
    case (corner)
      2'd0:    begin px = cur.ex; py = cur.y0; end
      2'd1:    begin px = cur.ex; py = cur.y1; end
      2'd2:    begin px = cur.x0; py = cur.ey; end
      default: begin px = cur.x1; py = cur.ey; end
    endcase
    d_a = half ? py : px;
    d_d = half ? tile_height : tile_width;
  end
  assign d_start = (state == S_DIV);

  btmmc_divider u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_a), .divisor(d_d),
    .done(d_done), .quotient(d_q)
  );

  // linear index: row * columns + col, checked for range
  logic signed [QUOT_W+10:0] lin;
  always_ff @(posedge clk) begin
    lin <= row * $signed({1'b0, map_columns}) + (QUOT_W+11)'(col);
  end

  assign q_stall  = (state != S_IDLE);
  assign busy     = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!valid || !stall);

  // memory: clear sweep, writes, registered read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[clr[AW-1:0]] <= 1'b0;
    end else if (state == S_IDLE && q_valid && !q_item.is_move
                 && 32'(q_item.tile_index) < MAP_TILES) begin
      mem[AW'(q_item.tile_index)] <= q_item.tile_blocked;
    end
    rd <= mem[addr];
  end
  assign addr = lin[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(MAP_TILES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            corner <= 2'd0;
            half   <= 1'b0;
            blk_x  <= 1'b0;
            blk_y  <= 1'b0;
            if (q_item.is_move) begin
              state <= S_DIV;
            end else begin
              res_x <= '0; res_y <= '0;
              res_sx <= 1'b0; res_sy <= 1'b0;
              state <= S_OUT;
            end
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (d_done) begin
            if (!half) begin
              col <= d_q; half <= 1'b1; state <= S_DIV;
            end else begin
              row <= d_q; half <= 1'b0; state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          bad <= (col < 0) || (row < 0) ||
                 (col >= $signed({1'b0, map_columns}));
          state <= S_READ;
        end
        S_READ: begin
          bad <= bad || (lin >= (QUOT_W+11)'(MAP_TILES));
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (bad || rd) begin
            if (corner[1]) blk_y <= 1'b1; else blk_x <= 1'b1;
          end
          if (corner == 2'd3) begin
            state  <= S_OUT;
            res_x  <= blk_x ? '0 : cur.move_x;
            res_y  <= (blk_y || bad || rd) ? '0 : cur.move_y;
            res_sx <= (cur.move_x != '0) && blk_x;
            res_sy <= (cur.move_y != '0) && (blk_y || bad || rd);
          end else begin
            corner <= corner + 2'd1;
            state  <= S_DIV;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: loads when empty or draining, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_load) begin
      valid     <= 1'b1;
      allowed_x <= res_x;
      allowed_y <= res_y;
      x_stopped <= res_sx;
      y_stopped <= res_sy;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(valid) |-> $past(state == S_OUT)) else $error("result without sequence");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    valid && stall |=> valid && $stable(allowed_x) && $stable(allowed_y)
    && $stable(x_stopped) && $stable(y_stopped))
    else $error("stalled result changed");
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    valid && x_stopped |-> allowed_x == '0) else $error("stopped x granted");
`endif

endmodule

>>> rtl/box_tile_map_move_check_core.sv
// Top level of the box tile map move check block.
// Depends on btmmc_pkg, btmmc_front, btmmc_back.
//
// channel   handshake            payload
// in        in_valid/in_stall    command .. move_y
// out       out_valid/out_stall  allowed_x, allowed_y, x_stopped, y_stopped
// cfg       cfg_we               cfg_index, cfg_data
//
// A write passes through queue, dispatch and result load before the next
// input transfer. A move checks 4 corners, each with 2 divides and the
// address, read and check states, plus the same three steps, on the one
// shared bit-serial floor divider (18 steps per divide). After reset the map
// is cleared one tile a cycle while no item is taken. Output stall holds
// the result register; the next result waits in the back end.
module box_tile_map_move_check_core
  import btmmc_pkg::*;
#(
  parameter int MAP_TILES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [11:0]        tile_index,
  input  logic               tile_blocked,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [9:0]         box_w,
  input  logic [9:0]         box_h,
  input  logic signed [10:0] move_x,
  input  logic signed [10:0] move_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [10:0] allowed_x,
  output logic signed [10:0] allowed_y,
  output logic               x_stopped,
  output logic               y_stopped,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  logic [8:0] tile_width, tile_height, map_columns;
  logic  q_valid, q_stall, busy;
  item_t q_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= 9'd16;
      tile_height <= 9'd16;
      map_columns <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILE_WIDTH:  tile_width  <= cfg_data;
        REG_TILE_HEIGHT: tile_height <= cfg_data;
        REG_MAP_COLUMNS: map_columns <= cfg_data;
        default: ;
      endcase
    end
  end

  btmmc_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall),
    .command(command), .tile_index(tile_index), .tile_blocked(tile_blocked),
    .pos_x(pos_x), .pos_y(pos_y), .box_w(box_w), .box_h(box_h),
    .move_x(move_x), .move_y(move_y), .busy(busy),
    .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
  );

  btmmc_back #(.MAP_TILES(MAP_TILES)) u_back (
    .clk(clk), .rst(rst), .tile_width(tile_width), .tile_height(tile_height),
    .map_columns(map_columns), .q_valid(q_valid), .q_stall(q_stall),
    .q_item(q_item), .busy(busy), .valid(out_valid), .stall(out_stall),
    .allowed_x(allowed_x), .allowed_y(allowed_y),
    .x_stopped(x_stopped), .y_stopped(y_stopped)
  );

endmodule
